[rtl/vbf_pkg.sv]
// ----------------------------------------------------------------------------
// vbf_pkg
// Shared types and codes of the voxel boundary face extractor.
// ----------------------------------------------------------------------------
package vbf_pkg;

   localparam int COORD_W = 6;
   localparam int GREY_W  = 8;
   localparam int FACE_W  = 3;
   localparam int NFACES  = 6;
   localparam int SIZE_W  = 7;
   localparam int REG_W   = 2;

   localparam logic [FACE_W-1:0] FACE_ZM = 3'd0;
   localparam logic [FACE_W-1:0] FACE_XM = 3'd1;
   localparam logic [FACE_W-1:0] FACE_ZP = 3'd2;
   localparam logic [FACE_W-1:0] FACE_XP = 3'd3;
   localparam logic [FACE_W-1:0] FACE_YM = 3'd4;
   localparam logic [FACE_W-1:0] FACE_YP = 3'd5;

   localparam logic [REG_W-1:0] REG_ALL_FACES = 2'd0;
   localparam logic [REG_W-1:0] REG_SIZE_X    = 2'd1;
   localparam logic [REG_W-1:0] REG_SIZE_Y    = 2'd2;
   localparam logic [REG_W-1:0] REG_SIZE_Z    = 2'd3;

   typedef enum logic [2:0] {
      P_IDLE,
      P_CTR,
      P_ZM,
      P_XM,
      P_ZP,
      P_YM,
      P_YP
   } phase_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [GREY_W-1:0]  shade;
      logic [NFACES-1:0]  mask;
   } job_type;

endpackage

[rtl/vbf_if.sv]
// ----------------------------------------------------------------------------
// vbf interfaces
// Sample, face and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vbf_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] grey;
   modport source (output valid, kind, grey, input ready);
   modport sink   (input valid, kind, grey, output ready);
endinterface

interface vbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] vox_x;
   logic [5:0] vox_y;
   logic [5:0] vox_z;
   logic [2:0] face;
   logic [7:0] shade;
   logic       last_face;
   modport source (output valid, vox_x, vox_y, vox_z, face, shade, last_face, input ready);
   modport sink   (input valid, vox_x, vox_y, vox_z, face, shade, last_face, output ready);
endinterface

interface vbf_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/vbf_ram.sv]
// ----------------------------------------------------------------------------
// vbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8193
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/vbf_fetch.sv]
// ----------------------------------------------------------------------------
// vbf_fetch
// Sample window store, center walk and neighbour reads; builds a face mask.
// ----------------------------------------------------------------------------
module vbf_fetch #(
   parameter int MAX_SIZE_X = 64,
   parameter int MAX_SIZE_Y = 64,
   parameter int MAX_SIZE_Z = 64
) (
   input  logic             clock,
   input  logic             reset,
   vbf_req_if.sink          req,
   vbf_csr_if.sink          csr,
   output logic             job_valid,
   output vbf_pkg::job_type job,
   input  logic             job_take
);
   import vbf_pkg::*;

   localparam int PLANE_MAX = MAX_SIZE_Y * MAX_SIZE_Z;
   localparam int DEPTH     = 2 * PLANE_MAX + 1;
   localparam int AW        = $clog2(DEPTH);
   localparam int PW        = $clog2(PLANE_MAX + 1);
   localparam int XW        = $clog2(MAX_SIZE_X);
   localparam int YW        = $clog2(MAX_SIZE_Y);
   localparam int ZW        = $clog2(MAX_SIZE_Z);
   localparam int SXW       = $clog2(MAX_SIZE_X + 1);
   localparam int SYW       = $clog2(MAX_SIZE_Y + 1);
   localparam int SZW       = $clog2(MAX_SIZE_Z + 1);

   logic              all_faces_ff;
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SXW-1:0]    sx;
   logic [SYW-1:0]    sy;
   logic [SZW-1:0]    sz;
   logic [PW-1:0]     plane;

   logic [XW-1:0]     cx_ff;
   logic [YW-1:0]     cy_ff;
   logic [ZW-1:0]     cz_ff;
   logic [PW-1:0]     fill_ff;
   logic [AW-1:0]     base_ff, wptr_ff;
   logic [AW-1:0]     base_inc, wptr_inc;

   phase_type         phase_ff, phase_in;
   logic [GREY_W-1:0] g_ff, v_ff, g_in;
   logic [XW-1:0]     ix_ff;
   logic [YW-1:0]     iy_ff;
   logic [ZW-1:0]     iz_ff;
   logic [NFACES-1:0] guard_ff, guard_in;
   logic [AW-1:0]     ibase_ff;
   logic [NFACES-1:0] mask_ff;
   logic              job_valid_ff;
   job_type           job_ff;

   logic              req_fire, csr_fire, priming, start, slot_free, size_wr;
   logic              last_z, last_y, last_x;
   logic              re;
   logic [AW-1:0]     raddr;
   logic [PW-1:0]     off;
   logic              sub;
   logic [AW:0]       sum;
   logic [GREY_W-1:0] rdata;
   logic [NFACES-1:0] mask_fin;

   function automatic logic hit(input logic af, input logic gd,
                                input logic [GREY_W-1:0] nb, input logic [GREY_W-1:0] v);
      logic [GREY_W-1:0] n;
      n = gd ? nb : '0;
      return af || (n < v);
   endfunction

   always_comb begin
      if (size_x_ff == '0) sx = SXW'(1);
      else if (32'(size_x_ff) > MAX_SIZE_X) sx = SXW'(MAX_SIZE_X);
      else sx = SXW'(size_x_ff);
      if (size_y_ff == '0) sy = SYW'(1);
      else if (32'(size_y_ff) > MAX_SIZE_Y) sy = SYW'(MAX_SIZE_Y);
      else sy = SYW'(size_y_ff);
      if (size_z_ff == '0) sz = SZW'(1);
      else if (32'(size_z_ff) > MAX_SIZE_Z) sz = SZW'(MAX_SIZE_Z);
      else sz = SZW'(size_z_ff);
   end

   assign plane     = PW'(sy) * PW'(sz);
   assign priming   = fill_ff < plane;
   assign slot_free = !job_valid_ff || job_take;
   assign req.ready = (phase_ff == P_IDLE) || (phase_ff == P_YP && slot_free);
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid;
   assign size_wr   = csr_fire && (csr.index != REG_ALL_FACES);
   assign start     = req_fire && !priming;
   assign g_in      = req.kind ? '0 : req.grey;

   assign last_z   = 32'(cz_ff) + 1 >= 32'(sz);
   assign last_y   = 32'(cy_ff) + 1 >= 32'(sy);
   assign last_x   = 32'(cx_ff) + 1 >= 32'(sx);
   assign base_inc = (base_ff == AW'(DEPTH - 1)) ? '0 : base_ff + AW'(1);
   assign wptr_inc = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);

   assign guard_in = {!last_y, cy_ff != '0, !last_x, !last_z, cx_ff != '0, cz_ff != '0};

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         P_IDLE: phase_in = start ? P_CTR : P_IDLE;
         P_CTR:  phase_in = (rdata == '0) ? P_IDLE : P_ZM;
         P_ZM:   phase_in = P_XM;
         P_XM:   phase_in = P_ZP;
         P_ZP:   phase_in = P_YM;
         P_YM:   phase_in = P_YP;
         P_YP: begin
            if (slot_free) phase_in = start ? P_CTR : P_IDLE;
         end
         default: phase_in = P_IDLE;
      endcase
   end

   always_comb begin
      re  = 1'b0;
      off = '0;
      sub = 1'b0;
      case (phase_ff)
         P_CTR: begin re = 1'b1; off = PW'(1); sub = 1'b1; end
         P_ZM:  begin re = 1'b1; off = plane;  sub = 1'b1; end
         P_XM:  begin re = 1'b1; off = PW'(1); sub = 1'b0; end
         P_ZP:  begin re = 1'b1; off = PW'(sz); sub = 1'b1; end
         P_YM:  begin re = 1'b1; off = PW'(sz); sub = 1'b0; end
         default: begin re = 1'b0; off = '0; sub = 1'b0; end
      endcase
      if (sub) sum = (AW+1)'(ibase_ff) + (AW+1)'(DEPTH) - (AW+1)'(off);
      else     sum = (AW+1)'(ibase_ff) + (AW+1)'(off);
      if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
      if (start) begin
         re    = 1'b1;
         raddr = base_ff;
      end else begin
         raddr = sum[AW-1:0];
      end
   end

   vbf_ram #(.WIDTH(GREY_W), .DEPTH(DEPTH)) u_window (
      .clock (clock),
      .we    (req_fire),
      .waddr (wptr_ff),
      .wdata (g_in),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      mask_fin    = mask_ff;
      mask_fin[5] = hit(all_faces_ff, guard_ff[5], rdata, v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_faces_ff <= 1'b0;
         size_x_ff    <= SIZE_W'(64);
         size_y_ff    <= SIZE_W'(64);
         size_z_ff    <= SIZE_W'(64);
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         fill_ff      <= '0;
         base_ff      <= '0;
         wptr_ff      <= '0;
         phase_ff     <= P_IDLE;
         job_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (csr_fire) begin
            case (csr.index)
               REG_ALL_FACES: all_faces_ff <= csr.data[0];
               REG_SIZE_X:    size_x_ff    <= csr.data;
               REG_SIZE_Y:    size_y_ff    <= csr.data;
               REG_SIZE_Z:    size_z_ff    <= csr.data;
               default:       all_faces_ff <= all_faces_ff;
            endcase
         end
         if (size_wr) begin
            cx_ff   <= '0;
            cy_ff   <= '0;
            cz_ff   <= '0;
            fill_ff <= '0;
            base_ff <= '0;
            wptr_ff <= '0;
         end else if (req_fire) begin
            wptr_ff <= wptr_inc;
            if (priming) begin
               fill_ff <= fill_ff + PW'(1);
            end else if (last_z && last_y && last_x) begin
               cx_ff   <= '0;
               cy_ff   <= '0;
               cz_ff   <= '0;
               fill_ff <= '0;
               base_ff <= '0;
               wptr_ff <= '0;
            end else begin
               base_ff <= base_inc;
               if (!last_z) begin
                  cz_ff <= cz_ff + ZW'(1);
               end else begin
                  cz_ff <= '0;
                  if (!last_y) begin
                     cy_ff <= cy_ff + YW'(1);
                  end else begin
                     cy_ff <= '0;
                     cx_ff <= cx_ff + XW'(1);
                  end
               end
            end
         end
         if (phase_ff == P_YP && slot_free) begin
            job_valid_ff <= 1'b1;
         end else if (job_take) begin
            job_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         g_ff     <= g_in;
         ix_ff    <= cx_ff;
         iy_ff    <= cy_ff;
         iz_ff    <= cz_ff;
         guard_ff <= guard_in;
         ibase_ff <= base_ff;
      end
      case (phase_ff)
         P_CTR: begin
            v_ff    <= rdata;
            mask_ff <= {2'b00, hit(all_faces_ff, guard_ff[3], g_ff, rdata), 3'b000};
         end
         P_ZM: mask_ff[0] <= hit(all_faces_ff, guard_ff[0], rdata, v_ff);
         P_XM: mask_ff[1] <= hit(all_faces_ff, guard_ff[1], rdata, v_ff);
         P_ZP: mask_ff[2] <= hit(all_faces_ff, guard_ff[2], rdata, v_ff);
         P_YM: mask_ff[4] <= hit(all_faces_ff, guard_ff[4], rdata, v_ff);
         P_YP: begin
            if (slot_free) begin
               job_ff.x     <= COORD_W'(ix_ff);
               job_ff.y     <= COORD_W'(iy_ff);
               job_ff.z     <= COORD_W'(iz_ff);
               job_ff.shade <= v_ff;
               job_ff.mask  <= mask_fin;
            end
         end
         default: mask_ff <= mask_ff;
      endcase
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;
endmodule

[rtl/vbf_emit.sv]
// ----------------------------------------------------------------------------
// vbf_emit
// Turns a face mask into face items, one per cycle while rsp is not stalled, with a registered output.
// ----------------------------------------------------------------------------
module vbf_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  vbf_pkg::job_type job,
   output logic             job_take,
   vbf_rsp_if.source        rsp
);
   import vbf_pkg::*;

   job_type           cur_ff;
   logic [NFACES-1:0] pend_ff, rest;
   logic [FACE_W-1:0] pick;
   logic              can_out, emit, out_valid_ff;
   logic [COORD_W-1:0] ox_ff, oy_ff, oz_ff;
   logic [FACE_W-1:0] of_ff;
   logic [GREY_W-1:0] os_ff;
   logic              ol_ff;

   always_comb begin
      pick = FACE_YP;
      for (int i = NFACES - 1; i >= 0; i--) begin
         if (pend_ff[i]) pick = FACE_W'(i);
      end
      rest       = pend_ff;
      rest[pick] = 1'b0;
   end

   assign can_out  = !out_valid_ff || rsp.ready;
   assign emit     = can_out && (pend_ff != '0);
   assign job_take = job_valid && ((pend_ff == '0) || (emit && rest == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= '0;
      end else begin
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (can_out) begin
            out_valid_ff <= 1'b0;
         end
         if (job_take) begin
            pend_ff <= job.mask;
         end else if (emit) begin
            pend_ff <= rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ox_ff <= cur_ff.x;
         oy_ff <= cur_ff.y;
         oz_ff <= cur_ff.z;
         of_ff <= pick;
         os_ff <= cur_ff.shade;
         ol_ff <= (rest == '0);
      end
      if (job_take) cur_ff <= job;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.vox_x     = ox_ff;
   assign rsp.vox_y     = oy_ff;
   assign rsp.vox_z     = oz_ff;
   assign rsp.face      = of_ff;
   assign rsp.shade     = os_ff;
   assign rsp.last_face = ol_ff;
endmodule

[rtl/voxel_boundary_face_extractor.sv]
// ----------------------------------------------------------------------------
// voxel_boundary_face_extractor
// Streams a grey volume through a two-plane window and emits boundary faces.
//
//   channel   dir   payload
//   req_port  in    kind, grey
//   rsp_port  out   vox_x, vox_y, vox_z, face, shade, last_face
//   csr_port  in    index, data (all_faces, size_x, size_y, size_z)
//
// A sample in the priming plane is only stored. A voxel reads the window RAM
// for its center and five stored neighbours (the x+1 neighbour is the arriving
// item), an empty voxel only its center; the faces drain at one per cycle while
// rsp_port is not stalled, overlapped with the next voxel's reads.
// Reset is synchronous; the window RAM is not cleared. A stalled rsp_port
// holds its item and backs up into req_port once the face buffer is full.
// ----------------------------------------------------------------------------
module voxel_boundary_face_extractor #(
   parameter int MAX_SIZE_X = 64,
   parameter int MAX_SIZE_Y = 64,
   parameter int MAX_SIZE_Z = 64
) (
   input logic         clock,
   input logic         reset,
   vbf_req_if.sink     req_port,
   vbf_rsp_if.source   rsp_port,
   vbf_csr_if.sink     csr_port
);
   import vbf_pkg::*;

   logic    job_valid, job_take;
   job_type job;

   vbf_fetch #(
      .MAX_SIZE_X(MAX_SIZE_X),
      .MAX_SIZE_Y(MAX_SIZE_Y),
      .MAX_SIZE_Z(MAX_SIZE_Z)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .req       (req_port),
      .csr       (csr_port),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take)
   );

   vbf_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take),
      .rsp       (rsp_port)
   );
endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams grey volumes of several shapes through the face extractor, with
// random idling on both channels, and checks every face against a predicted
// queue of faces that an in-bench copy of the two-plane window produces.
// ----------------------------------------------------------------------------
module testbench;
   import vbf_pkg::*;

   localparam int WIN_SLOTS   = 2 * 64 * 64 + 1;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [5:0] x;
      logic [5:0] y;
      logic [5:0] z;
      logic [2:0] face;
      logic [7:0] shade;
      logic       last;
   } face_rec;

   class face_scoreboard;
      logic [7:0] window [WIN_SLOTS];
      int unsigned cx, cy, cz, primed;
      bit          all_faces;
      logic [6:0]  size_x, size_y, size_z;
      face_rec     pending [$];
      int          errors;

      function new();
         foreach (window[i]) window[i] = 8'd0;
         cx = 0; cy = 0; cz = 0; primed = 0;
         all_faces = 1'b0;
         size_x = 7'd64; size_y = 7'd64; size_z = 7'd64;
         errors = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void queue_face(face_rec r);
         pending.insert(pending.size(), r);
      endfunction

      function int unsigned eff_size(logic [6:0] raw);
         if (raw == 7'd0) return 1;
         return (raw > 7'd64) ? 64 : int'(raw);
      endfunction

      function void write_reg(logic [1:0] idx, logic [6:0] data);
         case (idx)
            REG_ALL_FACES: all_faces = data[0];
            REG_SIZE_X:    size_x = data;
            REG_SIZE_Y:    size_y = data;
            REG_SIZE_Z:    size_z = data;
            default:       all_faces = all_faces;
         endcase
         if (idx != REG_ALL_FACES) begin
            cx = 0; cy = 0; cz = 0; primed = 0;
         end
      endfunction

      function void note_sample(logic kind, logic [7:0] grey);
         int unsigned sx, sy, sz, plane, lin;
         logic [7:0] g, v;
         logic [7:0] nb [6];
         logic [2:0] codes [6];
         face_rec    r;
         int         n;
         sx = eff_size(size_x);
         sy = eff_size(size_y);
         sz = eff_size(size_z);
         plane = sy * sz;
         g = kind ? 8'd0 : grey;
         lin = (cx * sy + cy) * sz + cz;
         if (primed > plane) primed = plane;
         window[(lin + primed) % WIN_SLOTS] = g;
         if (primed < plane) begin
            primed++;
            return;
         end
         v = window[lin % WIN_SLOTS];
         codes = '{FACE_ZM, FACE_XM, FACE_ZP, FACE_XP, FACE_YM, FACE_YP};
         if (v != 8'd0) begin
            nb[0] = (cz > 0)      ? window[(lin - 1) % WIN_SLOTS]     : 8'd0;
            nb[1] = (cx > 0)      ? window[(lin - plane) % WIN_SLOTS] : 8'd0;
            nb[2] = (cz + 1 < sz) ? window[(lin + 1) % WIN_SLOTS]     : 8'd0;
            nb[3] = (cx + 1 < sx) ? window[(lin + plane) % WIN_SLOTS] : 8'd0;
            nb[4] = (cy > 0)      ? window[(lin - sz) % WIN_SLOTS]    : 8'd0;
            nb[5] = (cy + 1 < sy) ? window[(lin + sz) % WIN_SLOTS]    : 8'd0;
            n = 0;
            for (int f = 0; f < 6; f++) begin
               if (all_faces || nb[f] < v) begin
                  r.x = cx[5:0]; r.y = cy[5:0]; r.z = cz[5:0];
                  r.face = codes[f]; r.shade = v; r.last = 1'b0;
                  queue_face(r);
                  n++;
               end
            end
            if (n > 0) pending[pending.size() - 1].last = 1'b1;
         end
         cz++;
         if (cz >= sz) begin
            cz = 0;
            cy++;
            if (cy >= sy) begin
               cy = 0;
               cx++;
               if (cx >= sx) begin
                  cx = 0; primed = 0;
               end
            end
         end
      endfunction

      task check_face(face_rec got);
         face_rec want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected face (%0d,%0d,%0d) code %0d",
                             got.x, got.y, got.z, got.face));
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x) report($sformatf("vox_x %0d, want %0d", got.x, want.x));
         if (got.y !== want.y) report($sformatf("vox_y %0d, want %0d", got.y, want.y));
         if (got.z !== want.z) report($sformatf("vox_z %0d, want %0d", got.z, want.z));
         if (got.face !== want.face)
            report($sformatf("face %0d, want %0d", got.face, want.face));
         if (got.shade !== want.shade)
            report($sformatf("shade %0d, want %0d", got.shade, want.shade));
         if (got.last !== want.last)
            report($sformatf("last_face %0d, want %0d", got.last, want.last));
      endtask
   endclass

   logic clock;
   logic reset;
   vbf_req_if req_port ();
   vbf_rsp_if rsp_port ();
   vbf_csr_if csr_port ();

   face_scoreboard faces;
   bit  quiet;
   int  cycles;
   int  sent;

   voxel_boundary_face_extractor dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port.sink),
      .rsp_port (rsp_port.source),
      .csr_port (csr_port.sink)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      face_rec got;
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         got.x = rsp_port.vox_x; got.y = rsp_port.vox_y; got.z = rsp_port.vox_z;
         got.face = rsp_port.face; got.shade = rsp_port.shade;
         got.last = rsp_port.last_face;
         faces.check_face(got);
      end
   end

   initial begin
      int hold;
      rsp_port.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 8);
            rsp_port.ready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_port.ready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [6:0] data);
      csr_port.valid = 1'b1;
      csr_port.index = idx;
      csr_port.data  = data;
      do @(posedge clock); while (!csr_port.ready);
      faces.write_reg(idx, data);
      @(negedge clock);
      csr_port.valid = 1'b0;
   endtask

   task automatic send_sample(logic kind, logic [7:0] grey);
      if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 8)) @(negedge clock);
      req_port.valid = 1'b1;
      req_port.kind  = kind;
      req_port.grey  = grey;
      do @(posedge clock); while (!req_port.ready);
      faces.note_sample(kind, grey);
      sent++;
      @(negedge clock);
      req_port.valid = 1'b0;
   endtask

   task automatic drain();
      while (faces.pending.size() != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (20) @(negedge clock);
   endtask

   task automatic random_volume(logic [6:0] rx, logic [6:0] ry, logic [6:0] rz,
                                logic [6:0] af, bit pause_mid);
      int unsigned voxels, pad;
      logic [7:0]  g;
      settle();
      write_csr(REG_ALL_FACES, af);
      write_csr(REG_SIZE_X, rx);
      write_csr(REG_SIZE_Y, ry);
      write_csr(REG_SIZE_Z, rz);
      voxels = faces.eff_size(rx) * faces.eff_size(ry) * faces.eff_size(rz);
      pad = faces.eff_size(ry) * faces.eff_size(rz);
      for (int i = 0; i < voxels; i++) begin
         if (pause_mid && i == voxels / 2) drain();
         g = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
         send_sample($urandom_range(0, 15) == 0, g);
      end
      for (int i = 0; i < pad; i++)
         send_sample($urandom_range(0, 9) != 0, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [7:0] peak [8];
      faces = new();
      quiet = 1'b0;
      cycles = 0;
      sent = 0;
      reset = 1'b1;
      req_port.valid = 1'b0; req_port.kind = 1'b0; req_port.grey = 8'd0;
      csr_port.valid = 1'b0; csr_port.index = REG_ALL_FACES; csr_port.data = 7'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all faces on a 2x2x2 cube with extreme greys
      write_csr(REG_ALL_FACES, 7'h7F);
      write_csr(REG_SIZE_X, 7'd2);
      write_csr(REG_SIZE_Y, 7'd2);
      write_csr(REG_SIZE_Z, 7'd2);
      peak = '{8'd255, 8'd1, 8'd0, 8'd128, 8'd127, 8'd255, 8'd85, 8'd170};
      foreach (peak[i]) send_sample(1'b0, peak[i]);
      repeat (4) send_sample(1'b1, 8'd0);
      settle();

      // darker faces only, zero size, misplaced padding and samples
      write_csr(REG_ALL_FACES, 7'd0);
      write_csr(REG_SIZE_X, 7'd3);
      write_csr(REG_SIZE_Y, 7'd0);
      write_csr(REG_SIZE_Z, 7'd2);
      send_sample(1'b0, 8'd200);
      send_sample(1'b1, 8'd255);
      send_sample(1'b0, 8'd200);
      send_sample(1'b0, 8'd201);
      send_sample(1'b0, 8'd1);
      send_sample(1'b0, 8'd255);
      send_sample(1'b0, 8'd77);
      send_sample(1'b0, 8'd255);

      random_volume(7'd127, 7'd1, 7'd1, 7'd0, 1'b0);
      random_volume(7'd1, 7'd1, 7'd32, 7'd1, 1'b1);
      while (sent < 170)
         random_volume(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                       7'($urandom_range(1, 4)), 7'($urandom_range(0, 127)), 1'b0);
      quiet = 1'b1;
      random_volume(7'd3, 7'd2, 7'd3, 7'd0, 1'b0);
      random_volume(7'd2, 7'd3, 7'd2, 7'd1, 1'b0);

      drain();
      repeat (40) @(negedge clock);
      foreach (faces.pending[i])
         faces.report($sformatf("face (%0d,%0d,%0d) code %0d never came",
                      faces.pending[i].x, faces.pending[i].y,
                      faces.pending[i].z, faces.pending[i].face));
      if (faces.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/vbf_pkg.sv
rtl/vbf_if.sv
rtl/vbf_ram.sv
rtl/vbf_fetch.sv
rtl/vbf_emit.sv
rtl/voxel_boundary_face_extractor.sv
sim/testbench.sv
